// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif

// next-cycle implication
`ifndef ASSERT_OFF
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/rpg_pkg.sv -----
package rpg_pkg;

  localparam int MaxPixels = 64;
  localparam int IdxW      = $clog2(MaxPixels);
  localparam int CountW    = IdxW + 1;
  localparam int ChanW     = 8;
  localparam int ColorW    = 4 * ChanW;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 32;
  localparam int MsW       = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PIXEL_COUNT    = 3'd0,
    CFG_BRIGHTNESS     = 3'd1,
    CFG_FRAME_DELAY_MS = 3'd2,
    CFG_HUE_STEP       = 3'd3,
    CFG_BAND_DELAY_MS  = 3'd4,
    CFG_BAND_STEP      = 3'd5,
    CFG_RUN_LENGTH_MS  = 3'd6,
    CFG_RESTORE_COLOR  = 3'd7
  } cfg_reg_e;

  localparam logic ActionTick  = 1'b0;
  localparam logic ActionStart = 1'b1;

endpackage

// ----- design/rpg_if.sv -----
interface rpg_in_if;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [rpg_pkg::CountW-1:0] band_length;

  modport source (output valid, action, band_length, input ready);
  modport sink   (input valid, action, band_length, output ready);
endinterface

interface rpg_out_if;
  logic                       valid;
  logic                       ready;
  logic [rpg_pkg::IdxW-1:0]   pixel_index;
  logic [rpg_pkg::ColorW-1:0] pixel_color;
  logic                       last;

  modport source (output valid, pixel_index, pixel_color, last, input ready);
  modport sink   (input valid, pixel_index, pixel_color, last, output ready);
endinterface

// ----- design/rainbow_pixel_generator.sv -----
// rainbow pixel generator for a WRGB led strip. each input transaction is either a start
// command (loads the white band from band_length, clears hue and timers, arms the run) or a
// one-millisecond tick. a tick while running bumps the timers and may emit a whole frame of
// pixel_count transactions (clamped to 1..64) on the output, pixel 0 first, last set on the
// final pixel; when the run time is used up the frame carries restore_color and the block
// stops. the block handles one input transaction at a time and drops ready until its frame
// is fully delivered and the band ends are wrapped. a frame of n pixels is built one pixel at
// a time: a single shared 9-bit subtractor works out i*256/n by repeated subtraction (at most
// 256 subtractions over the frame), then one multiplier scales the four channels one per
// cycle, then the same subtractor reduces band head and tail modulo n. a restore frame skips
// these steps. configuration is written through a plain write port; the user must write it
// only while idle, and the block itself does not enforce this.
module rainbow_pixel_generator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  rpg_in_if.sink                      item_i,
  rpg_out_if.source                   pixel_o,
  input  logic                        cfg_we_i,
  input  logic [rpg_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rpg_pkg::CfgDataW-1:0] cfg_data_i
);

`include "assert_macros.svh"

  localparam int IdxW   = rpg_pkg::IdxW;
  localparam int CountW = rpg_pkg::CountW;
  localparam int ChanW  = rpg_pkg::ChanW;
  localparam int MsW    = rpg_pkg::MsW;
  localparam int PosW   = CountW + 1;   // band position before modulo
  localparam int RemW   = ChanW + 1;    // division remainder plus 256

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_COLOR,
    S_SCALE,
    S_PIX,
    S_RESTORE,
    S_MOD_HEAD,
    S_MOD_TAIL
  } state_e;

  // configuration registers
  logic [CountW-1:0]          pixel_count_q;
  logic [ChanW-1:0]           brightness_q;
  logic [MsW-1:0]             frame_delay_q;
  logic [ChanW-1:0]           hue_step_q;
  logic [MsW-1:0]             band_delay_q;
  logic [IdxW-1:0]            band_step_q;
  logic [MsW-1:0]             run_length_q;
  logic [rpg_pkg::ColorW-1:0] restore_color_q;

  // animation state
  state_e            state_q;
  logic              running_q;
  logic [MsW-1:0]    elapsed_q;
  logic [MsW-1:0]    since_frame_q;
  logic [MsW-1:0]    since_band_q;
  logic              move_pend_q;
  logic [PosW-1:0]   head_q;
  logic [PosW-1:0]   tail_q;
  logic [ChanW-1:0]  hue_q;

  // frame sequencer
  logic [IdxW-1:0]            idx_q;
  logic [ChanW-1:0]           quot_q;
  logic [RemW-1:0]            rem_q;
  logic [1:0]                 ch_q;
  logic [ChanW-1:0]           xval_q [4];
  logic [rpg_pkg::ColorW-1:0] color_q;
  logic                       out_valid_q;
  logic                       last_q;

  logic [CountW-1:0] eff_n;
  logic              item_acc;
  logic              pix_acc;
  logic [CountW-1:0] start_head;
  logic              idx_at_end;

  // shared subtractor
  logic [RemW-1:0] sub_a;
  logic [RemW-1:0] sub_b;
  logic [RemW-1:0] sub_diff;
  logic            sub_ge;

  // timer increments for the tick
  logic [MsW-1:0] elapsed_inc;
  logic [MsW-1:0] since_frame_inc;
  logic [MsW-1:0] since_band_inc;

  // colour wheel
  logic [ChanW-1:0] pos;
  logic [ChanW-1:0] wp;
  logic [ChanW-1:0] wq;
  logic [ChanW+1:0] wq3;
  logic [ChanW-1:0] tq;
  logic [ChanW-1:0] wr;
  logic [ChanW-1:0] wg;
  logic [ChanW-1:0] wb;
  logic [PosW-1:0]  idx_pos;
  logic             in_band;
  logic [ChanW-1:0] scaled;

  // clamp the strip length into one..max
  always_comb begin
    if (pixel_count_q == '0) begin
      eff_n = CountW'(1);
    end else if (pixel_count_q > CountW'(rpg_pkg::MaxPixels)) begin
      eff_n = CountW'(rpg_pkg::MaxPixels);
    end else begin
      eff_n = pixel_count_q;
    end
  end

  assign item_i.ready = (state_q == S_IDLE);
  assign item_acc     = item_i.valid && item_i.ready;
  assign pix_acc      = pixel_o.valid && pixel_o.ready;

  // band head on start wraps within 7 bits, zero length gives 127
  assign start_head = item_i.band_length - CountW'(1);
  assign idx_at_end = (CountW'(idx_q) + CountW'(1) == eff_n);

  assign pixel_o.valid       = out_valid_q;
  assign pixel_o.pixel_index = idx_q;
  assign pixel_o.pixel_color = color_q;
  assign pixel_o.last        = last_q;

  // subtractor operands: remainder in the divide loop, band ends in the modulo passes
  always_comb begin
    sub_b = RemW'(eff_n);
    case (state_q)
      S_MOD_HEAD: sub_a = RemW'(head_q);
      S_MOD_TAIL: sub_a = RemW'(tail_q);
      default:    sub_a = rem_q;
    endcase
    sub_diff = sub_a - sub_b;
    sub_ge   = (sub_a >= sub_b);
  end

  // saturating millisecond counters
  assign elapsed_inc     = (elapsed_q == '1) ? elapsed_q : elapsed_q + MsW'(1);
  assign since_frame_inc = (since_frame_q == '1) ? since_frame_q : since_frame_q + MsW'(1);
  assign since_band_inc  = (since_band_q == '1) ? since_band_q : since_band_q + MsW'(1);

  // wheel position and band membership for the current pixel
  always_comb begin
    pos = quot_q + hue_q;
    wp  = ~pos;
    wr  = '0;
    wg  = '0;
    wb  = '0;
    if (wp < ChanW'(85)) begin
      wq = wp;
    end else if (wp < ChanW'(170)) begin
      wq = wp - ChanW'(85);
    end else begin
      wq = wp - ChanW'(170);
    end
    wq3 = 10'(wq) * 10'd3;
    tq  = wq3[ChanW-1:0];
    if (wp < ChanW'(85)) begin
      wr = ChanW'(255) - tq;
      wb = tq;
    end else if (wp < ChanW'(170)) begin
      wg = tq;
      wb = ChanW'(255) - tq;
    end else begin
      wr = tq;
      wg = ChanW'(255) - tq;
    end
    idx_pos = PosW'(idx_q);
    if (tail_q <= head_q) begin
      in_band = (idx_pos >= tail_q) && (idx_pos <= head_q);
    end else begin
      in_band = (idx_pos >= tail_q) || (idx_pos <= head_q);
    end
  end

  rpg_scale u_scale (
    .x_i    (xval_q[ch_q]),
    .gain_i (brightness_q),
    .y_o    (scaled)
  );

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_count_q   <= CountW'(64);
      brightness_q    <= ChanW'(255);
      frame_delay_q   <= MsW'(10);
      hue_step_q      <= ChanW'(1);
      band_delay_q    <= MsW'(10);
      band_step_q     <= IdxW'(1);
      run_length_q    <= '0;
      restore_color_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rpg_pkg::CFG_PIXEL_COUNT:    pixel_count_q   <= cfg_data_i[CountW-1:0];
        rpg_pkg::CFG_BRIGHTNESS:     brightness_q    <= cfg_data_i[ChanW-1:0];
        rpg_pkg::CFG_FRAME_DELAY_MS: frame_delay_q   <= cfg_data_i[MsW-1:0];
        rpg_pkg::CFG_HUE_STEP:       hue_step_q      <= cfg_data_i[ChanW-1:0];
        rpg_pkg::CFG_BAND_DELAY_MS:  band_delay_q    <= cfg_data_i[MsW-1:0];
        rpg_pkg::CFG_BAND_STEP:      band_step_q     <= cfg_data_i[IdxW-1:0];
        rpg_pkg::CFG_RUN_LENGTH_MS:  run_length_q    <= cfg_data_i[MsW-1:0];
        rpg_pkg::CFG_RESTORE_COLOR:  restore_color_q <= cfg_data_i[rpg_pkg::ColorW-1:0];
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      running_q     <= 1'b0;
      elapsed_q     <= '0;
      since_frame_q <= '0;
      since_band_q  <= '0;
      move_pend_q   <= 1'b0;
      head_q        <= '0;
      tail_q        <= '0;
      hue_q         <= '0;
      idx_q         <= '0;
      quot_q        <= '0;
      rem_q         <= '0;
      ch_q          <= '0;
      xval_q        <= '{default: '0};
      color_q       <= '0;
      out_valid_q   <= 1'b0;
      last_q        <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (item_acc) begin
            if (item_i.action == rpg_pkg::ActionStart) begin
              head_q        <= PosW'(start_head);
              tail_q        <= '0;
              hue_q         <= '0;
              elapsed_q     <= '0;
              since_frame_q <= '0;
              since_band_q  <= '0;
              move_pend_q   <= 1'b1;
              running_q     <= 1'b1;
            end else if (running_q) begin
              elapsed_q     <= elapsed_inc;
              since_band_q  <= since_band_inc;
              idx_q         <= '0;
              if (run_length_q != '0 && elapsed_inc >= run_length_q) begin
                // run over: restore frame, nothing else moves
                since_frame_q <= since_frame_inc;
                running_q     <= 1'b0;
                color_q       <= restore_color_q;
                last_q        <= (eff_n == CountW'(1));
                out_valid_q   <= 1'b1;
                state_q       <= S_RESTORE;
              end else if (since_frame_inc > frame_delay_q) begin
                since_frame_q <= '0;
                quot_q        <= '0;
                rem_q         <= '0;
                state_q       <= S_DIV;
              end else begin
                since_frame_q <= since_frame_inc;
              end
            end
          end
        end

        S_DIV: begin
          // quot ends at floor(idx*256/n), rem carries over to the next pixel
          if (sub_ge) begin
            rem_q  <= sub_diff;
            quot_q <= quot_q + ChanW'(1);
          end else begin
            state_q <= S_COLOR;
          end
        end

        S_COLOR: begin
          if (in_band) begin
            xval_q <= '{ChanW'(255), ChanW'(0), ChanW'(0), ChanW'(0)};
          end else begin
            xval_q <= '{ChanW'(0), wr, wg, wb};
          end
          ch_q    <= '0;
          state_q <= S_SCALE;
        end

        S_SCALE: begin
          // byte lane 3 - ch: white, red, green, blue
          color_q[(3 - ch_q) * ChanW +: ChanW] <= scaled;
          ch_q <= ch_q + 2'd1;
          if (ch_q == 2'd3) begin
            last_q      <= idx_at_end;
            out_valid_q <= 1'b1;
            state_q     <= S_PIX;
          end
        end

        S_PIX: begin
          if (pix_acc) begin
            out_valid_q <= 1'b0;
            if (last_q) begin
              if (move_pend_q || since_band_q > band_delay_q) begin
                head_q       <= head_q + PosW'(band_step_q);
                tail_q       <= tail_q + PosW'(band_step_q);
                since_band_q <= '0;
                move_pend_q  <= 1'b0;
              end
              hue_q   <= hue_q + hue_step_q;
              state_q <= S_MOD_HEAD;
            end else begin
              idx_q   <= idx_q + IdxW'(1);
              rem_q   <= rem_q + RemW'(256);
              state_q <= S_DIV;
            end
          end
        end

        S_RESTORE: begin
          if (pix_acc) begin
            if (last_q) begin
              out_valid_q <= 1'b0;
              state_q     <= S_IDLE;
            end else begin
              idx_q  <= idx_q + IdxW'(1);
              last_q <= (CountW'(idx_q) + CountW'(1) == eff_n - CountW'(1));
            end
          end
        end

        S_MOD_HEAD: begin
          if (sub_ge) begin
            head_q <= sub_diff[PosW-1:0];
          end else begin
            state_q <= S_MOD_TAIL;
          end
        end

        S_MOD_TAIL: begin
          if (sub_ge) begin
            tail_q <= sub_diff[PosW-1:0];
          end else begin
            state_q <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // input side and output side are never both open
  `ASSERT_IMPL(a_no_overlap, clk_i, rst_ni, item_i.ready, !pixel_o.valid)
  // the flagged pixel is the last one of the strip
  `ASSERT_IMPL(a_last_index, clk_i, rst_ni, pixel_o.valid && pixel_o.last, idx_at_end)
  // a frame ends cleanly once its last transaction leaves
  `ASSERT_NEXT(a_frame_end, clk_i, rst_ni, pixel_o.valid && pixel_o.ready && pixel_o.last, !pixel_o.valid)

endmodule

// ----- design/rpg_scale.sv -----
module rpg_scale (
  input  logic [rpg_pkg::ChanW-1:0] x_i,
  input  logic [rpg_pkg::ChanW-1:0] gain_i,
  output logic [rpg_pkg::ChanW-1:0] y_o
);

  logic [2*rpg_pkg::ChanW-1:0] prod;
  logic [2*rpg_pkg::ChanW:0]   corr;

  // floor(prod / 255) for any product of two 8-bit values
  assign prod = x_i * gain_i;
  assign corr = {1'b0, prod} + {{(rpg_pkg::ChanW+1){1'b0}}, prod[2*rpg_pkg::ChanW-1 -: rpg_pkg::ChanW]}
              + {{(2*rpg_pkg::ChanW){1'b0}}, 1'b1};
  assign y_o  = corr[2*rpg_pkg::ChanW-1 -: rpg_pkg::ChanW];

endmodule

// ----- dv/tb_rainbow_pixel_generator.sv -----
module tb_rainbow_pixel_generator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   IdxW        = rpg_pkg::IdxW;
  localparam int   CountW      = rpg_pkg::CountW;
  localparam int   ColorW      = rpg_pkg::ColorW;
  localparam int   CfgDataW    = rpg_pkg::CfgDataW;
  localparam int   MsW         = rpg_pkg::MsW;
  localparam logic ActionTick  = rpg_pkg::ActionTick;
  localparam logic ActionStart = rpg_pkg::ActionStart;

  // one pixel transaction as it leaves the block
  typedef struct packed {
    logic [IdxW-1:0]   index;
    logic [ColorW-1:0] color;
    logic              last;
  } pixel_t;

  // what a row of the directed plan does
  //   ROW_CFG     register write, block idle first
  //   ROW_PREDICT item, frame worked out by the strip model
  //   ROW_QUIET   item known to produce nothing
  //   ROW_FLAT    item known to produce one solid-color frame (color in data)
  typedef enum logic [1:0] {ROW_CFG, ROW_PREDICT, ROW_QUIET, ROW_FLAT} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    rpg_pkg::cfg_reg_e   reg_sel;
    logic [CfgDataW-1:0] data;
    logic                action;
    logic [CountW-1:0]   band_len;
  } row_t;

  localparam int NumRows = 40;

  localparam row_t PLAN [NumRows] = '{
    // tick before any start is dropped
    '{ROW_QUIET,   rpg_pkg::CFG_PIXEL_COUNT,    32'd0,         ActionTick,  7'd5},
    '{ROW_CFG,     rpg_pkg::CFG_PIXEL_COUNT,    32'd4,         ActionTick,  7'd0},
    '{ROW_CFG,     rpg_pkg::CFG_FRAME_DELAY_MS, 32'd0,         ActionTick,  7'd0},
    // zero band length wraps head to 127, whole first frame is white
    '{ROW_QUIET,   rpg_pkg::CFG_PIXEL_COUNT,    32'd0,         ActionStart, 7'd0},
    '{ROW_FLAT,    rpg_pkg::CFG_PIXEL_COUNT,    32'hFF00_0000, ActionTick,  7'd0},
    '{ROW_PREDICT, rpg_pkg::CFG_PIXEL_COUNT,    32'd0,         ActionTick,  7'd0},
    '{ROW_QUIET,   rpg_pkg::CFG_PIXEL_COUNT,    32'd0,         ActionStart, 7'd1},
    // band_length is ignored on a tick
    '{ROW_PREDICT, rpg_pkg::CFG_PIXEL_COUNT,    32'd0,         ActionTick,  7'd127},
    '{ROW_PREDICT, rpg_pkg::CFG_PIXEL_COUNT,    32'd0,         ActionTick,  7'd64},
    // zero brightness blanks the band too
    '{ROW_CFG,     rpg_pkg::CFG_BRIGHTNESS,     32'd0,         ActionTick,  7'd0},
    '{ROW_QUIET,   rpg_pkg::CFG_PIXEL_COUNT,    32'd0,         ActionStart, 7'd0},
    '{ROW_FLAT,    rpg_pkg::CFG_PIXEL_COUNT,    32'h0000_0000, ActionTick,  7'd0},
    // zero pixel count means one pixel, run ends on the first tick
    '{ROW_CFG,     rpg_pkg::CFG_BRIGHTNESS,     32'd255,       ActionTick,  7'd0},
    '{ROW_CFG,     rpg_pkg::CFG_PIXEL_COUNT,    32'd0,         ActionTick,  7'd0},
    '{ROW_CFG,     rpg_pkg::CFG_RUN_LENGTH_MS,  32'd1,         ActionTick,  7'd0},
    '{ROW_CFG,     rpg_pkg::CFG_RESTORE_COLOR,  32'hFFFF_FFFF, ActionTick,  7'd0},
    '{ROW_QUIET,   rpg_pkg::CFG_PIXEL_COUNT,    32'd0,         ActionStart, 7'd127},
    '{ROW_FLAT,    rpg_pkg::CFG_PIXEL_COUNT,    32'hFFFF_FFFF, ActionTick,  7'd0},
    '{ROW_QUIET,   rpg_pkg::CFG_PIXEL_COUNT,    32'd0,         ActionTick,  7'd0},
    // oversized pixel count clamps to the full strip
    '{ROW_CFG,     rpg_pkg::CFG_PIXEL_COUNT,    32'd127,       ActionTick,  7'd0},
    '{ROW_CFG,     rpg_pkg::CFG_RUN_LENGTH_MS,  32'd0,         ActionTick,  7'd0},
    '{ROW_CFG,     rpg_pkg::CFG_RESTORE_COLOR,  32'd0,         ActionTick,  7'd0},
    '{ROW_QUIET,   rpg_pkg::CFG_PIXEL_COUNT,    32'd0,         ActionStart, 7'd64},
    '{ROW_FLAT,    rpg_pkg::CFG_PIXEL_COUNT,    32'hFF00_0000, ActionTick,  7'd0},
    // band longer than the strip, head used as given on the first frame
    '{ROW_QUIET,   rpg_pkg::CFG_PIXEL_COUNT,    32'd0,         ActionStart, 7'd100},
    '{ROW_FLAT,    rpg_pkg::CFG_PIXEL_COUNT,    32'hFF00_0000, ActionTick,  7'd0},
    '{ROW_PREDICT, rpg_pkg::CFG_PIXEL_COUNT,    32'd0,         ActionTick,  7'd0},
    // big steps, half brightness, frame every second tick
    '{ROW_CFG,     rpg_pkg::CFG_HUE_STEP,       32'd255,       ActionTick,  7'd0},
    '{ROW_CFG,     rpg_pkg::CFG_BAND_STEP,      32'd63,        ActionTick,  7'd0},
    '{ROW_CFG,     rpg_pkg::CFG_BAND_DELAY_MS,  32'd0,         ActionTick,  7'd0},
    '{ROW_CFG,     rpg_pkg::CFG_BRIGHTNESS,     32'd128,       ActionTick,  7'd0},
    '{ROW_CFG,     rpg_pkg::CFG_FRAME_DELAY_MS, 32'd1,         ActionTick,  7'd0},
    '{ROW_CFG,     rpg_pkg::CFG_PIXEL_COUNT,    32'd16,        ActionTick,  7'd0},
    '{ROW_QUIET,   rpg_pkg::CFG_PIXEL_COUNT,    32'd0,         ActionStart, 7'd5},
    '{ROW_QUIET,   rpg_pkg::CFG_PIXEL_COUNT,    32'd0,         ActionTick,  7'd0},
    '{ROW_PREDICT, rpg_pkg::CFG_PIXEL_COUNT,    32'd0,         ActionTick,  7'd0},
    '{ROW_QUIET,   rpg_pkg::CFG_PIXEL_COUNT,    32'd0,         ActionTick,  7'd0},
    '{ROW_PREDICT, rpg_pkg::CFG_PIXEL_COUNT,    32'd0,         ActionTick,  7'd0},
    '{ROW_QUIET,   rpg_pkg::CFG_PIXEL_COUNT,    32'd0,         ActionTick,  7'd0},
    '{ROW_PREDICT, rpg_pkg::CFG_PIXEL_COUNT,    32'd0,         ActionTick,  7'd0}
  };

  localparam int NumPhases     = 12;
  localparam int PhaseItems    = 33;
  // covers band head/tail reduction after the last pixel, with margin
  localparam int SettleCycles  = 600;
  localparam int IdlePercent   = 37;

  logic clk_i = 1'b0;
  logic rst_ni;

  rpg_in_if  item_if ();
  rpg_out_if pixel_if ();

  logic                cfg_we;
  rpg_pkg::cfg_reg_e   cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  rainbow_pixel_generator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_if),
    .pixel_o    (pixel_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // register mirror, reset values
  logic [CountW-1:0] cfg_count       = 7'd64;
  logic [7:0]        cfg_bright      = 8'd255;
  logic [MsW-1:0]    cfg_frame_delay = 16'd10;
  logic [7:0]        cfg_hue_step    = 8'd1;
  logic [MsW-1:0]    cfg_band_delay  = 16'd10;
  logic [5:0]        cfg_band_step   = 6'd1;
  logic [MsW-1:0]    cfg_run_ms      = 16'd0;
  logic [ColorW-1:0] cfg_restore     = 32'd0;

  // strip model state; head and tail kept wide since they overshoot before the wrap
  bit                anim_on         = 1'b0;
  logic [MsW-1:0]    ms_total        = '0;
  logic [MsW-1:0]    ms_since_frame  = '0;
  logic [MsW-1:0]    ms_since_band   = '0;
  bit                band_kick       = 1'b0;
  int unsigned       head            = 0;
  int unsigned       tail            = 0;
  logic [7:0]        hue             = '0;

  pixel_t frame_pixels [$];   // pixels produced by the latest item
  pixel_t pixels_due   [$];   // pixels still owed by the block
  int     mismatches   = 0;
  bit     steady       = 1'b0;  // no idling on either side while set
  bit     dirty        = 1'b0;  // items sent since the last settle

  function automatic int unsigned strip_count();
    if (cfg_count == 0) return 1;
    if (cfg_count > rpg_pkg::MaxPixels) return rpg_pkg::MaxPixels;
    return 32'(cfg_count);
  endfunction

  function automatic logic [7:0] dim(input int unsigned x);
    return 8'((x * cfg_bright) / 255);
  endfunction

  // color wheel, packed as {white, red, green, blue}
  function automatic logic [ColorW-1:0] wheel_color(input logic [7:0] pos);
    int unsigned p;
    p = 255 - pos;
    if (p < 85) return {8'h00, dim(255 - 3 * p), 8'h00, dim(3 * p)};
    if (p < 170) begin
      p = p - 85;
      return {8'h00, 8'h00, dim(3 * p), dim(255 - 3 * p)};
    end
    p = p - 170;
    return {8'h00, dim(3 * p), dim(255 - 3 * p), 8'h00};
  endfunction

  // advance the strip model by one item, leaving its pixels in frame_pixels
  function automatic void strip_step(input logic act, input logic [CountW-1:0] blen);
    int unsigned       n;
    logic [CountW-1:0] start_head;
    logic              in_band;
    pixel_t            px;
    n = strip_count();
    frame_pixels.delete();
    if (act == ActionStart) begin
      start_head     = blen - 1'b1;
      head           = 32'(start_head);
      tail           = 0;
      hue            = '0;
      ms_total       = '0;
      ms_since_frame = '0;
      ms_since_band  = '0;
      band_kick      = 1'b1;
      anim_on        = 1'b1;
      return;
    end
    if (!anim_on) return;
    // saturating millisecond counters
    if (ms_total != '1) ms_total = ms_total + 1'b1;
    if (ms_since_frame != '1) ms_since_frame = ms_since_frame + 1'b1;
    if (ms_since_band != '1) ms_since_band = ms_since_band + 1'b1;
    // run over: restore frame and stop, nothing else on this tick
    if (cfg_run_ms != 0 && ms_total >= cfg_run_ms) begin
      for (int unsigned i = 0; i < n; i++) begin
        px.index = IdxW'(i);
        px.color = cfg_restore;
        px.last  = (i == n - 1);
        frame_pixels.push_back(px);
      end
      anim_on = 1'b0;
      return;
    end
    if (ms_since_frame <= cfg_frame_delay) return;
    ms_since_frame = '0;
    for (int unsigned i = 0; i < n; i++) begin
      in_band = (i >= tail && i <= head) || (tail > head && (i >= tail || i <= head));
      px.index = IdxW'(i);
      px.color = in_band ? {dim(255), 24'h0} : wheel_color(8'((i * 256) / n + hue));
      px.last  = (i == n - 1);
      frame_pixels.push_back(px);
    end
    // first frame after a start always moves the band
    if (band_kick || ms_since_band > cfg_band_delay) begin
      head          = head + cfg_band_step;
      tail          = tail + cfg_band_step;
      ms_since_band = '0;
      band_kick     = 1'b0;
    end
    hue  = hue + cfg_hue_step;
    head = head % n;
    tail = tail % n;
  endfunction

  // present one item, with random idle cycles ahead of it, until it is taken
  task automatic apply_item(input row_kind_e kind, input logic act,
                            input logic [CountW-1:0] blen, input logic [ColorW-1:0] flat);
    int unsigned n;
    pixel_t      px;
    while (!steady && $urandom_range(0, 99) < IdlePercent) begin
      @(negedge clk_i);
      item_if.valid       <= 1'b0;
      item_if.action      <= 1'($urandom);
      item_if.band_length <= CountW'($urandom);
    end
    @(negedge clk_i);
    item_if.valid       <= 1'b1;
    item_if.action      <= act;
    item_if.band_length <= blen;
    do @(posedge clk_i); while (!item_if.ready);
    dirty = 1'b1;
    n = strip_count();
    strip_step(act, blen);
    case (kind)
      ROW_PREDICT: foreach (frame_pixels[k]) pixels_due.push_back(frame_pixels[k]);
      ROW_FLAT: begin
        for (int unsigned i = 0; i < n; i++) begin
          px.index = IdxW'(i);
          px.color = flat;
          px.last  = (i == n - 1);
          pixels_due.push_back(px);
        end
      end
      default: ;
    endcase
  endtask

  // bring the block to rest: every owed pixel delivered, then the trailing wrap done
  task automatic settle();
    @(negedge clk_i);
    item_if.valid <= 1'b0;
    if (dirty) begin
      while (pixels_due.size() != 0) @(posedge clk_i);
      repeat (SettleCycles) @(posedge clk_i);
      dirty = 1'b0;
    end
  endtask

  task automatic write_reg(input rpg_pkg::cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    case (idx)
      rpg_pkg::CFG_PIXEL_COUNT:    cfg_count       = data[CountW-1:0];
      rpg_pkg::CFG_BRIGHTNESS:     cfg_bright      = data[7:0];
      rpg_pkg::CFG_FRAME_DELAY_MS: cfg_frame_delay = data[MsW-1:0];
      rpg_pkg::CFG_HUE_STEP:       cfg_hue_step    = data[7:0];
      rpg_pkg::CFG_BAND_DELAY_MS:  cfg_band_delay  = data[MsW-1:0];
      rpg_pkg::CFG_BAND_STEP:      cfg_band_step   = data[5:0];
      rpg_pkg::CFG_RUN_LENGTH_MS:  cfg_run_ms      = data[MsW-1:0];
      rpg_pkg::CFG_RESTORE_COLOR:  cfg_restore     = data;
      default: ;
    endcase
  endtask

  // sink side stalls at random unless in a steady stretch
  always @(negedge clk_i) begin
    pixel_if.ready <= steady || ($urandom_range(0, 99) >= IdlePercent);
  end

  // every pixel transaction is checked against the oldest owed pixel
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && pixel_if.valid && pixel_if.ready) begin
      if (pixels_due.size() == 0) begin
        $error("unexpected pixel transaction, index %0d color %h",
               pixel_if.pixel_index, pixel_if.pixel_color);
        mismatches = mismatches + 1;
      end else begin
        want = pixels_due.pop_front();
        if (pixel_if.pixel_index !== want.index) begin
          $error("pixel_index expected %0d got %0d", want.index, pixel_if.pixel_index);
          mismatches = mismatches + 1;
        end
        if (pixel_if.pixel_color !== want.color) begin
          $error("pixel_color expected %h got %h", want.color, pixel_if.pixel_color);
          mismatches = mismatches + 1;
        end
        if (pixel_if.last !== want.last) begin
          $error("last expected %b got %b", want.last, pixel_if.last);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  initial begin
    int unsigned       spent;
    logic              act;
    logic [CountW-1:0] blen;
    logic [CfgDataW-1:0] val;

    rst_ni              = 1'b0;
    item_if.valid       = 1'b0;
    item_if.action      = ActionTick;
    item_if.band_length = '0;
    pixel_if.ready      = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = rpg_pkg::CFG_PIXEL_COUNT;
    cfg_data            = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed plan
    foreach (PLAN[k]) begin
      if (PLAN[k].kind == ROW_CFG) begin
        settle();
        write_reg(PLAN[k].reg_sel, PLAN[k].data);
      end else begin
        apply_item(PLAN[k].kind, PLAN[k].action, PLAN[k].band_len, PLAN[k].data);
      end
    end

    // random phases, each under fresh register settings
    for (int phase = 0; phase < NumPhases; phase++) begin
      settle();
      steady = (phase == 4);
      case ($urandom_range(0, 7))
        0:       val = 0;
        1:       val = 1;
        2:       val = 64;
        3:       val = 127;
        default: val = $urandom_range(2, 16);
      endcase
      write_reg(rpg_pkg::CFG_PIXEL_COUNT, val);
      case ($urandom_range(0, 3))
        0:       val = 0;
        1:       val = 255;
        default: val = $urandom_range(0, 255);
      endcase
      write_reg(rpg_pkg::CFG_BRIGHTNESS, val);
      val = ($urandom_range(0, 9) == 0) ? 32'hFFFF : $urandom_range(0, 3);
      write_reg(rpg_pkg::CFG_FRAME_DELAY_MS, val);
      write_reg(rpg_pkg::CFG_HUE_STEP, $urandom_range(0, 255));
      case ($urandom_range(0, 4))
        0:       val = 32'hFFFF;
        1:       val = 0;
        default: val = $urandom_range(0, 6);
      endcase
      write_reg(rpg_pkg::CFG_BAND_DELAY_MS, val);
      write_reg(rpg_pkg::CFG_BAND_STEP, $urandom_range(0, 63));
      case ($urandom_range(0, 3))
        0:       val = 0;
        1:       val = 32'hFFFF;
        default: val = $urandom_range(1, 40);
      endcase
      write_reg(rpg_pkg::CFG_RUN_LENGTH_MS, val);
      write_reg(rpg_pkg::CFG_RESTORE_COLOR, $urandom);

      // mostly running animations; ticks while stopped are noise and not counted
      spent = 0;
      while (spent < PhaseItems) begin
        if (anim_on) act = ($urandom_range(0, 99) < 8) ? ActionStart : ActionTick;
        else         act = ($urandom_range(0, 99) < 85) ? ActionStart : ActionTick;
        if ($urandom_range(0, 3) == 0) blen = CountW'($urandom);
        else                           blen = CountW'($urandom_range(1, strip_count()));
        if (act == ActionStart || anim_on) spent++;
        apply_item(ROW_PREDICT, act, blen, '0);
      end
    end
    steady = 1'b0;

    settle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

endmodule
